/* rtl/mscm_pkg.sv */
// ----------------------------------------------------------------------------
// mscm_pkg
// shared widths, status codes, table write request and default time table
// for the move sequence cost matcher
// ----------------------------------------------------------------------------
package mscm_pkg;

    localparam int TABLE_DEPTH = 57;
    localparam int INDEX_W     = 6;
    localparam int COST_W      = 16;

    typedef logic [INDEX_W-1:0] idx_t;
    typedef logic [COST_W-1:0]  cost_t;
    typedef logic [1:0]         status_t;

    localparam status_t STATUS_MATCH        = 2'd0;
    localparam status_t STATUS_NO_PATH      = 2'd1;
    localparam status_t STATUS_NOT_TERMINAL = 2'd2;

    typedef struct packed {
        logic  en;
        idx_t  index;
        cost_t cost;
    } table_wr_t;

    // time of each pattern after reset
    function automatic cost_t default_cost(idx_t idx);
        cost_t c;
        case (idx)
            6'd0:  c = 16'd97;
            6'd1:  c = 16'd118;
            6'd2:  c = 16'd178;
            6'd3:  c = 16'd146;
            6'd4:  c = 16'd257;
            6'd5:  c = 16'd118;
            6'd6:  c = 16'd178;
            6'd7:  c = 16'd146;
            6'd8:  c = 16'd257;
            6'd9:  c = 16'd118;
            6'd10: c = 16'd111;
            6'd11: c = 16'd146;
            6'd12: c = 16'd118;
            6'd13: c = 16'd111;
            6'd14: c = 16'd146;
            6'd15: c = 16'd69;
            6'd16: c = 16'd69;
            6'd17: c = 16'd189;
            6'd18: c = 16'd278;
            6'd19: c = 16'd363;
            6'd20: c = 16'd445;
            6'd21: c = 16'd523;
            6'd22: c = 16'd600;
            6'd23: c = 16'd673;
            6'd24: c = 16'd745;
            6'd25: c = 16'd815;
            6'd26: c = 16'd883;
            6'd27: c = 16'd949;
            6'd28: c = 16'd1014;
            6'd29: c = 16'd1077;
            6'd30: c = 16'd1087;
            6'd31: c = 16'd136;
            6'd32: c = 16'd200;
            6'd33: c = 16'd263;
            6'd34: c = 16'd324;
            6'd35: c = 16'd383;
            6'd36: c = 16'd440;
            6'd37: c = 16'd497;
            6'd38: c = 16'd551;
            6'd39: c = 16'd605;
            6'd40: c = 16'd657;
            6'd41: c = 16'd708;
            6'd42: c = 16'd759;
            6'd43: c = 16'd808;
            6'd44: c = 16'd856;
            6'd45: c = 16'd904;
            6'd46: c = 16'd950;
            6'd47: c = 16'd996;
            6'd48: c = 16'd1041;
            6'd49: c = 16'd1086;
            6'd50: c = 16'd1130;
            6'd51: c = 16'd1173;
            6'd52: c = 16'd1215;
            6'd53: c = 16'd1257;
            6'd54: c = 16'd1299;
            6'd55: c = 16'd1339;
            6'd56: c = 16'd1380;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/mscm_cost_table.sv */
// ----------------------------------------------------------------------------
// mscm_cost_table
// loadable pattern time table: one write port, one registered read port,
// entries read as their default time until first written
// ----------------------------------------------------------------------------
module mscm_cost_table
    import mscm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  table_wr_t wr,
    input  logic      rd_en,
    input  idx_t      rd_index,
    output cost_t     rd_cost
);

    cost_t                   mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  written_reg;
    cost_t                   rd_data_reg;
    cost_t                   dflt_reg;
    logic                    rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.index] <= wr.cost;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
            dflt_reg    <= default_cost(rd_index);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.index] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_index];
            end
        end
    end

    assign rd_cost = rd_written_reg ? rd_data_reg : dflt_reg;

endmodule

/* rtl/move_sequence_cost_matcher.sv */
// ----------------------------------------------------------------------------
// move_sequence_cost_matcher
// walks a fixed trie of robot move sequences and reports the matched
// pattern and its time from a loadable table
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle while symbol_stall is low,
// move symbols and table writes alike. The trie step is done in the
// accepting cycle; on a last symbol the table is read into a register,
// and the result moves on to the output register once that register is
// free or being emptied. The read stage can take a new result while the
// output register waits on result_stall, and symbol_stall rises only
// when both are full. Table writes with an entry_index above 56 are
// dropped. Unknown paths give match_status 1, and sequences ending inside
// the trie give 2, both with zero time and index.
// ----------------------------------------------------------------------------
module move_sequence_cost_matcher
    import mscm_pkg::*;
#(
    parameter int MAX_FORWARD_RUN     = 16,
    parameter int MAX_ALTERNATING_RUN = 28
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       symbol_valid,
    output logic       symbol_stall,
    input  logic       kind,
    input  logic [1:0] direction,
    input  logic       last_symbol,
    input  idx_t       entry_index,
    input  cost_t      entry_time,
    output logic       result_valid,
    input  logic       result_stall,
    output cost_t      path_time,
    output idx_t       pattern_index,
    output status_t    match_status
);

    localparam logic [4:0] FWD_LIMIT =
        5'((MAX_FORWARD_RUN < 16) ? MAX_FORWARD_RUN : 16);
    localparam logic [4:0] ALT_LIMIT =
        5'((MAX_ALTERNATING_RUN < 28) ? MAX_ALTERNATING_RUN : 28);

    localparam logic [1:0] DIR_F = 2'd0;
    localparam logic [1:0] DIR_R = 2'd1;
    localparam logic [1:0] DIR_L = 2'd3;

    localparam logic [3:0] S_ROOT  = 4'd0;
    localparam logic [3:0] S_F     = 4'd1;
    localparam logic [3:0] S_FL    = 4'd2;
    localparam logic [3:0] S_FLL   = 4'd3;
    localparam logic [3:0] S_FR    = 4'd4;
    localparam logic [3:0] S_FRR   = 4'd5;
    localparam logic [3:0] S_L     = 4'd6;
    localparam logic [3:0] S_LL    = 4'd7;
    localparam logic [3:0] S_R     = 4'd8;
    localparam logic [3:0] S_RR    = 4'd9;
    localparam logic [3:0] S_FWD   = 4'd10;
    localparam logic [3:0] S_ALT_R = 4'd11;
    localparam logic [3:0] S_ALT_L = 4'd12;
    localparam logic [3:0] S_LEAF  = 4'd13;

    logic [3:0] pos_reg, pos_next, pos_step;
    logic [4:0] run_reg, run_next, run_step;
    logic       fail_reg, fail_next, fail_step;

    logic       sym_accept, move, p_load, p_advance;
    idx_t       res_idx;
    status_t    res_status;
    logic       res_term;

    logic       p_valid_reg, p_valid_next;
    idx_t       p_idx_reg;
    status_t    p_status_reg;
    logic       p_term_reg;
    cost_t      rd_cost;

    logic       o_valid_reg, o_valid_next;
    cost_t      o_time_reg;
    idx_t       o_idx_reg;
    status_t    o_status_reg;

    table_wr_t  tbl_wr;

    // read stage moves on when the output register is free or being emptied
    assign p_advance    = !o_valid_reg || !result_stall;
    assign symbol_stall = p_valid_reg && !p_advance;
    assign sym_accept   = symbol_valid && !symbol_stall;
    assign move         = sym_accept && !kind;
    assign p_load       = move && last_symbol;

    // one trie step
    always_comb
    begin
        pos_step  = pos_reg;
        run_step  = run_reg;
        fail_step = fail_reg;
        if (!fail_reg)
        begin
            fail_step = 1'b1;
            case (pos_reg)
                S_ROOT:
                begin
                    if (direction == DIR_F)      begin pos_step = S_F; fail_step = 1'b0; end
                    else if (direction == DIR_R) begin pos_step = S_R; fail_step = 1'b0; end
                    else if (direction == DIR_L) begin pos_step = S_L; fail_step = 1'b0; end
                end
                S_F:
                begin
                    if (direction == DIR_F)
                    begin
                        pos_step  = S_FWD;
                        run_step  = 5'd2;
                        fail_step = 1'b0;
                    end
                    else if (direction == DIR_L) begin pos_step = S_FL; fail_step = 1'b0; end
                    else if (direction == DIR_R) begin pos_step = S_FR; fail_step = 1'b0; end
                end
                S_FL:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_R)      begin pos_step = S_LEAF; run_step = 5'd1; end
                    else if (direction == DIR_F) begin pos_step = S_LEAF; run_step = 5'd2; end
                    else if (direction == DIR_L) pos_step = S_FLL;
                    else fail_step = 1'b1;
                end
                S_FLL:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_R)      begin pos_step = S_LEAF; run_step = 5'd3; end
                    else if (direction == DIR_F) begin pos_step = S_LEAF; run_step = 5'd4; end
                    else fail_step = 1'b1;
                end
                S_FR:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_L)      begin pos_step = S_LEAF; run_step = 5'd5; end
                    else if (direction == DIR_F) begin pos_step = S_LEAF; run_step = 5'd6; end
                    else if (direction == DIR_R) pos_step = S_FRR;
                    else fail_step = 1'b1;
                end
                S_FRR:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_L)      begin pos_step = S_LEAF; run_step = 5'd7; end
                    else if (direction == DIR_F) begin pos_step = S_LEAF; run_step = 5'd8; end
                    else fail_step = 1'b1;
                end
                S_L:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_F)      begin pos_step = S_LEAF; run_step = 5'd9; end
                    else if (direction == DIR_L) pos_step = S_LL;
                    else if (direction == DIR_R) begin pos_step = S_ALT_R; run_step = 5'd2; end
                    else fail_step = 1'b1;
                end
                S_LL:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_R)      begin pos_step = S_LEAF; run_step = 5'd10; end
                    else if (direction == DIR_F) begin pos_step = S_LEAF; run_step = 5'd11; end
                    else fail_step = 1'b1;
                end
                S_R:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_F)      begin pos_step = S_LEAF; run_step = 5'd12; end
                    else if (direction == DIR_R) pos_step = S_RR;
                    else if (direction == DIR_L) begin pos_step = S_ALT_L; run_step = 5'd2; end
                    else fail_step = 1'b1;
                end
                S_RR:
                begin
                    fail_step = 1'b0;
                    if (direction == DIR_L)      begin pos_step = S_LEAF; run_step = 5'd13; end
                    else if (direction == DIR_F) begin pos_step = S_LEAF; run_step = 5'd14; end
                    else fail_step = 1'b1;
                end
                S_FWD:
                begin
                    if (direction == DIR_F && run_reg < FWD_LIMIT)
                    begin
                        run_step  = 5'(run_reg + 5'd1);
                        fail_step = 1'b0;
                    end
                end
                S_ALT_R:
                begin
                    if (direction == DIR_L && run_reg < ALT_LIMIT)
                    begin
                        run_step  = 5'(run_reg + 5'd1);
                        pos_step  = S_ALT_L;
                        fail_step = 1'b0;
                    end
                end
                S_ALT_L:
                begin
                    if (direction == DIR_R && run_reg < ALT_LIMIT)
                    begin
                        run_step  = 5'(run_reg + 5'd1);
                        pos_step  = S_ALT_R;
                        fail_step = 1'b0;
                    end
                end
                default:
                begin
                    fail_step = 1'b1;
                end
            endcase
        end
    end

    // classify where the sequence ends
    always_comb
    begin
        res_idx    = '0;
        res_status = STATUS_NOT_TERMINAL;
        res_term   = 1'b0;
        if (fail_step)
        begin
            res_status = STATUS_NO_PATH;
        end
        else
        begin
            case (pos_step)
                S_LEAF:
                begin
                    res_idx  = {1'b0, run_step};
                    res_term = 1'b1;
                end
                S_FWD:
                begin
                    // lone FF has its own entry, longer runs start at 17
                    res_idx  = (run_step == 5'd2) ? 6'd0 : 6'({1'b0, run_step} + 6'd14);
                    res_term = 1'b1;
                end
                S_ALT_R,
                S_ALT_L:
                begin
                    if (run_step == 5'd2)
                    begin
                        res_idx = (pos_step == S_ALT_R) ? 6'd15 : 6'd16;
                    end
                    else
                    begin
                        res_idx = 6'({1'b0, run_step} + 6'd28);
                    end
                    res_term = 1'b1;
                end
                default:
                begin
                    res_term = 1'b0;
                end
            endcase
            if (res_term)
            begin
                res_status = STATUS_MATCH;
            end
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        run_next  = run_reg;
        fail_next = fail_reg;
        if (move)
        begin
            if (last_symbol)
            begin
                pos_next  = S_ROOT;
                run_next  = '0;
                fail_next = 1'b0;
            end
            else
            begin
                pos_next  = pos_step;
                run_next  = run_step;
                fail_next = fail_step;
            end
        end
    end

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (p_load)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_advance)
        begin
            p_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg && result_stall;
        if (p_valid_reg && p_advance)
        begin
            o_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= S_ROOT;
            run_reg     <= '0;
            fail_reg    <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            run_reg     <= run_next;
            fail_reg    <= fail_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_idx_reg    <= res_idx;
            p_status_reg <= res_status;
            p_term_reg   <= res_term;
        end
        if (p_valid_reg && p_advance)
        begin
            o_time_reg   <= p_term_reg ? rd_cost : '0;
            o_idx_reg    <= p_idx_reg;
            o_status_reg <= p_status_reg;
        end
    end

    assign tbl_wr.en    = sym_accept && kind && (entry_index < idx_t'(TABLE_DEPTH));
    assign tbl_wr.index = entry_index;
    assign tbl_wr.cost  = entry_time;

    mscm_cost_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_en    (p_load),
        .rd_index (res_idx),
        .rd_cost  (rd_cost)
    );

    assign result_valid  = o_valid_reg;
    assign path_time     = o_time_reg;
    assign pattern_index = o_idx_reg;
    assign match_status  = o_status_reg;

endmodule
